// ===== rtl/core/slfd_pkg.sv =====
// ---------------------------------------------------------------------------
// slfd_pkg
// Shared types and constants for the sync/length frame deframer.
// ---------------------------------------------------------------------------
package slfd_pkg;

   localparam int unsigned BYTE_W     = 8;
   localparam int unsigned CSR_IDX_W  = 1;
   localparam int unsigned CSR_DATA_W = 8;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_FIRST_SYNC  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_SECOND_SYNC = 1'b1;

   // register reset values
   localparam logic [BYTE_W-1:0] FIRST_SYNC_RST  = 8'hBC;
   localparam logic [BYTE_W-1:0] SECOND_SYNC_RST = 8'hAC;

   // result kinds
   localparam logic KIND_PAYLOAD = 1'b0;
   localparam logic KIND_END     = 1'b1;

   // parser phases
   localparam logic [1:0] PH_HUNT    = 2'd0;
   localparam logic [1:0] PH_LENGTH  = 2'd1;
   localparam logic [1:0] PH_PAYLOAD = 2'd2;
   localparam logic [1:0] PH_TRAILER = 2'd3;

   typedef struct packed {
      logic [BYTE_W-1:0] first_sync;
      logic [BYTE_W-1:0] second_sync;
   } sync_cfg_type;

   typedef struct packed {
      logic              valid;
      logic [BYTE_W-1:0] rx_byte;
   } in_beat_type;

endpackage

// ===== rtl/core/slfd_if.sv =====
// ---------------------------------------------------------------------------
// slfd channel interfaces
// Valid/ready byte channel in, result channel out.
// ---------------------------------------------------------------------------
interface slfd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface slfd_rsp_if;
   logic       valid;
   logic       ready;
   logic       item_kind;
   logic [7:0] data_byte;
   logic       frame_ok;
   logic [7:0] frame_length;

   modport source (output valid, output item_kind, output data_byte,
                   output frame_ok, output frame_length, input ready);
   modport sink   (input valid, input item_kind, input data_byte,
                   input frame_ok, input frame_length, output ready);
endinterface

// ===== rtl/core/slfd_csr.sv =====
// ---------------------------------------------------------------------------
// slfd_csr
// Sync byte registers, written through the plain write port.
// ---------------------------------------------------------------------------
module slfd_csr
   import slfd_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wr_data,
   output sync_cfg_type          cfg
);

   sync_cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_FIRST_SYNC:  cfg_in.first_sync  = csr_wr_data[BYTE_W-1:0];
            CSR_SECOND_SYNC: cfg_in.second_sync = csr_wr_data[BYTE_W-1:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.first_sync  <= FIRST_SYNC_RST;
         cfg_ff.second_sync <= SECOND_SYNC_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== rtl/core/slfd_in_stage.sv =====
// ---------------------------------------------------------------------------
// slfd_in_stage
// Input register: holds one received beat until the parser takes it.
// ---------------------------------------------------------------------------
module slfd_in_stage
   import slfd_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   slfd_req_if.sink     req_chan,
   input  logic         take_ok,
   output in_beat_type  beat
);

   logic              valid_ff, valid_in;
   logic [BYTE_W-1:0] byte_ff, byte_in;
   logic              accept;

   assign req_chan.ready = !valid_ff || take_ok;
   assign accept         = req_chan.valid && req_chan.ready;

   always_comb begin
      valid_in = valid_ff;
      byte_in  = byte_ff;
      if (accept) begin
         valid_in = 1'b1;
         byte_in  = req_chan.rx_byte;
      end else if (take_ok) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
   end

   assign beat.valid   = valid_ff;
   assign beat.rx_byte = byte_ff;

endmodule

// ===== rtl/core/slfd_frame_fsm.sv =====
// ---------------------------------------------------------------------------
// slfd_frame_fsm
// Frame parser and result register: sync hunt, length, payload, trailer.
// ---------------------------------------------------------------------------
module slfd_frame_fsm
   import slfd_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  in_beat_type   beat,
   input  sync_cfg_type  cfg,
   output logic          take_ok,
   slfd_rsp_if.source    rsp_chan
);

   logic [1:0]        phase_ff, phase_in;
   logic              first_seen_ff, first_seen_in;
   logic [BYTE_W-1:0] remaining_ff, remaining_in;
   logic [BYTE_W-1:0] exp_len_ff, exp_len_in;

   logic              out_valid_ff, out_valid_in;
   logic              kind_ff, kind_in;
   logic [BYTE_W-1:0] data_ff, data_in;
   logic              ok_ff, ok_in;
   logic [BYTE_W-1:0] len_ff, len_in;

   logic              out_free;
   logic              take;
   logic              emit;
   logic [BYTE_W-1:0] b;
   logic [BYTE_W-1:0] rem_dec;

   assign out_free = !out_valid_ff || rsp_chan.ready;
   assign take_ok  = out_free;
   assign take     = beat.valid && out_free;
   assign b        = beat.rx_byte;
   assign rem_dec  = remaining_ff - BYTE_W'(1);

   always_comb begin
      phase_in      = phase_ff;
      first_seen_in = first_seen_ff;
      remaining_in  = remaining_ff;
      exp_len_in    = exp_len_ff;
      emit          = 1'b0;
      kind_in       = KIND_PAYLOAD;
      data_in       = '0;
      ok_in         = 1'b0;
      len_in        = '0;
      if (take) begin
         unique case (phase_ff)
            PH_HUNT: begin
               // marker completion wins over re-arming on a first sync
               if (first_seen_ff && b == cfg.second_sync) begin
                  first_seen_in = 1'b0;
                  phase_in      = PH_LENGTH;
               end else begin
                  first_seen_in = (b == cfg.first_sync);
               end
            end
            PH_LENGTH: begin
               if (b == '0) begin
                  phase_in      = PH_HUNT;
                  first_seen_in = 1'b0;
               end else begin
                  exp_len_in   = b;
                  remaining_in = b;
                  phase_in     = PH_PAYLOAD;
               end
            end
            PH_PAYLOAD: begin
               remaining_in = rem_dec;
               if (rem_dec == '0) begin
                  phase_in = PH_TRAILER;
               end
               emit    = 1'b1;
               data_in = b;
            end
            PH_TRAILER: begin
               emit          = 1'b1;
               kind_in       = KIND_END;
               ok_in         = (b == cfg.second_sync);
               len_in        = exp_len_ff;
               phase_in      = PH_HUNT;
               first_seen_in = 1'b0;
               remaining_in  = '0;
               exp_len_in    = '0;
            end
            default: phase_in = PH_HUNT;
         endcase
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (out_free) begin
         out_valid_in = take && emit;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_HUNT;
         first_seen_ff <= 1'b0;
         remaining_ff  <= '0;
         exp_len_ff    <= '0;
         out_valid_ff  <= 1'b0;
      end else begin
         phase_ff      <= phase_in;
         first_seen_ff <= first_seen_in;
         remaining_ff  <= remaining_in;
         exp_len_ff    <= exp_len_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free) begin
         kind_ff <= kind_in;
         data_ff <= data_in;
         ok_ff   <= ok_in;
         len_ff  <= len_in;
      end
   end

   assign rsp_chan.valid        = out_valid_ff;
   assign rsp_chan.item_kind    = kind_ff;
   assign rsp_chan.data_byte    = data_ff;
   assign rsp_chan.frame_ok     = ok_ff;
   assign rsp_chan.frame_length = len_ff;

   a_payload_fields: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && kind_ff == KIND_PAYLOAD |-> !ok_ff && len_ff == '0)
      else $error("payload beat carries end-of-frame fields");

   a_end_fields: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && kind_ff == KIND_END |-> data_ff == '0 && len_ff != '0)
      else $error("end beat with data or zero length");

   a_payload_emits: assert property (@(posedge clock) disable iff (reset)
      take && phase_ff == PH_PAYLOAD |=> out_valid_ff && kind_ff == KIND_PAYLOAD)
      else $error("payload byte did not reach the result register");

   a_length_load: assert property (@(posedge clock) disable iff (reset)
      take && phase_ff == PH_LENGTH && b != '0
      |=> phase_ff == PH_PAYLOAD && remaining_ff == exp_len_ff
          && remaining_ff == $past(b))
      else $error("length byte not loaded");

   a_hunt_silent: assert property (@(posedge clock) disable iff (reset)
      take && (phase_ff == PH_HUNT || phase_ff == PH_LENGTH) |=> !out_valid_ff)
      else $error("result emitted outside payload or trailer");

endmodule

// ===== rtl/core/sync_length_frame_deframer_unit.sv =====
// ---------------------------------------------------------------------------
// sync_length_frame_deframer_unit
// Hunts two sync bytes, reads a length byte, passes the payload and checks
// the trailer against the second sync byte.
// ---------------------------------------------------------------------------
//  channel   dir  beat contents
//  req_chan  in   rx_byte
//  rsp_chan  out  item_kind, data_byte, frame_ok, frame_length
//  csr_*     in   write enable, index, 8-bit data (0 first sync, 1 second)
//
//  One byte per cycle sustained while rsp_chan is ready; input register,
//  parser, result register. A payload or end beat passes the input
//  register and then the result register before it appears on rsp_chan.
//  Synchronous active-high reset: back to hunting, sync bytes 0xBC / 0xAC.
//  A stalled rsp_chan holds its beat; the input register keeps one more byte
//  and req_chan.ready drops only while both are full.
// ---------------------------------------------------------------------------
module sync_length_frame_deframer_unit
   import slfd_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   slfd_req_if.sink              req_chan,
   slfd_rsp_if.source            rsp_chan,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wr_data
);

   sync_cfg_type cfg;
   in_beat_type  beat;
   logic         take_ok;

   slfd_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .cfg         (cfg)
   );

   slfd_in_stage u_in_stage (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .take_ok  (take_ok),
      .beat     (beat)
   );

   slfd_frame_fsm u_frame_fsm (
      .clock    (clock),
      .reset    (reset),
      .beat     (beat),
      .cfg      (cfg),
      .take_ok  (take_ok),
      .rsp_chan (rsp_chan)
   );

endmodule
